### design/tspf_pkg.sv
`default_nettype none

package tspf_pkg;

    localparam int PID_BITS   = 13;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic {
        REQ_STREAM = 1'b0,
        REQ_TABLE  = 1'b1
    } t_req;

    typedef enum logic {
        KIND_PID  = 1'b0,
        KIND_BODY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] hdr;
        logic        pkt_last;
    } t_entry;

endpackage

`default_nettype wire

### design/tspf_front.sv
`default_nettype none

module tspf_front #(
    parameter int PACKET_BYTES = 188,
    parameter int PID_COUNT    = 8192
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire tspf_pkg::t_req                 i_req,
    input  wire logic [7:0]                     i_byte,
    input  wire logic [tspf_pkg::PID_BITS-1:0]  i_pid,
    input  wire logic                           i_drop,
    output logic                                o_push,
    output tspf_pkg::t_entry                    o_entry,
    input  wire logic                           i_full
);

    localparam int AW = $clog2(PID_COUNT);
    localparam int PW = $clog2(PACKET_BYTES);

    logic                       mem [PID_COUNT];
    logic                       r_rd;
    logic                       r_clr_busy;
    logic [AW-1:0]              r_clr_cnt;
    logic [PW-1:0]              r_pos;
    logic [15:0]                r_hdr;
    logic                       r_keep;

    logic                       r_s1_valid;
    tspf_pkg::t_kind            r_s1_kind;
    logic [7:0]                 r_s1_byte;
    logic [15:0]                r_s1_hdr;
    logic                       r_s1_last;
    logic                       r_s1_oor;

    logic                       accept;
    logic                       is_stream;
    logic                       pos_last;
    logic [tspf_pkg::PID_BITS-1:0] pkt_pid;
    logic                       tbl_in_range;
    logic                       pkt_in_range;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic                       mem_wd;
    logic                       mem_re;
    logic                       keep_now;
    logic                       s1_go;

    always_comb begin
        accept       = i_valid && o_ready;
        is_stream    = (i_req == tspf_pkg::REQ_STREAM);
        pos_last     = (r_pos == PW'(PACKET_BYTES - 1));
        pkt_pid      = {r_hdr[4:0], i_byte};
        tbl_in_range = ({1'b0, i_pid} < (tspf_pkg::PID_BITS + 1)'(PID_COUNT));
        pkt_in_range = ({1'b0, pkt_pid} < (tspf_pkg::PID_BITS + 1)'(PID_COUNT));
        mem_we       = r_clr_busy || (accept && !is_stream && tbl_in_range);
        mem_wa       = r_clr_busy ? r_clr_cnt : i_pid[AW-1:0];
        mem_wd       = r_clr_busy ? 1'b0 : i_drop;
        mem_re       = accept && is_stream && (r_pos == PW'(2));
        keep_now     = (r_s1_kind == tspf_pkg::KIND_PID) ? (!r_s1_oor && !r_rd) : r_keep;
        s1_go        = r_s1_valid && (!keep_now || !i_full);
        o_push       = r_s1_valid && keep_now && !i_full;
        o_ready      = !r_clr_busy && (!r_s1_valid || s1_go);
        o_entry.kind     = r_s1_kind;
        o_entry.data     = r_s1_byte;
        o_entry.hdr      = r_s1_hdr;
        o_entry.pkt_last = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[pkt_pid[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r_pos      <= '0;
            r_hdr      <= '0;
            r_keep     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_kind  <= tspf_pkg::KIND_BODY;
            r_s1_oor   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(PID_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (s1_go && (r_s1_kind == tspf_pkg::KIND_PID)) begin
                r_keep <= keep_now;
            end
            if (accept && is_stream) begin
                r_pos <= pos_last ? '0 : r_pos + PW'(1);
                if (r_pos == PW'(0)) begin
                    r_hdr[15:8] <= i_byte;
                end
                if (r_pos == PW'(1)) begin
                    r_hdr[7:0] <= i_byte;
                end
            end
            if (accept && is_stream && (r_pos >= PW'(2))) begin
                r_s1_valid <= 1'b1;
                r_s1_kind  <= (r_pos == PW'(2)) ? tspf_pkg::KIND_PID : tspf_pkg::KIND_BODY;
                r_s1_oor   <= !pkt_in_range;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_stream && (r_pos >= PW'(2))) begin
            r_s1_byte <= i_byte;
            r_s1_hdr  <= r_hdr;
            r_s1_last <= pos_last;
        end
    end

endmodule

`default_nettype wire

### design/tspf_fifo.sv
`default_nettype none

module tspf_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tspf_pkg::t_entry  i_entry,
    output logic                   o_full,
    output logic                   o_valid,
    output tspf_pkg::t_entry       o_entry,
    input  wire logic              i_pop
);

    localparam int AW = tspf_pkg::FIFO_AW;

    tspf_pkg::t_entry r_mem [tspf_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_full  = (r_cnt == (AW + 1)'(tspf_pkg::FIFO_DEPTH));
        o_valid = (r_cnt != '0);
        o_entry = r_mem[r_rp];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/tspf_back.sv
`default_nettype none

module tspf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tspf_pkg::t_entry  i_entry,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_byte,
    output logic                   o_run_last,
    output logic                   o_pkt_last
);

    localparam logic [1:0] SUB_B0 = 2'd0;
    localparam logic [1:0] SUB_B1 = 2'd1;

    logic [1:0] r_sub;
    logic       r_ovalid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_pkt_last;
    logic       load;
    logic       last_word;
    logic [7:0] word;

    always_comb begin
        load = i_valid && (!r_ovalid || i_ready);
        unique case (i_entry.kind)
            tspf_pkg::KIND_PID: begin
                last_word = (r_sub != SUB_B0) && (r_sub != SUB_B1);
                if (r_sub == SUB_B0) begin
                    word = i_entry.hdr[15:8];
                end else if (r_sub == SUB_B1) begin
                    word = i_entry.hdr[7:0];
                end else begin
                    word = i_entry.data;
                end
            end
            default: begin
                last_word = 1'b1;
                word      = i_entry.data;
            end
        endcase
        o_pop      = load && last_word;
        o_valid    = r_ovalid;
        o_byte     = r_byte;
        o_run_last = r_run_last;
        o_pkt_last = r_pkt_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub    <= SUB_B0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_sub    <= last_word ? SUB_B0 : r_sub + 2'd1;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= word;
            r_run_last <= last_word;
            r_pkt_last <= last_word && i_entry.pkt_last;
        end
    end

endmodule

`default_nettype wire

### design/ts_pid_drop_filter_top.sv
// Transport stream PID filter. The slave channel carries one word per cycle:
// a stream byte (tuser low) or a drop table write (tuser high). The stream is
// taken as packet aligned from the first byte after reset. Bytes 0 and 1 of
// each packet are held; at byte 2 the PID is looked up in the drop table and
// a kept packet is sent out unchanged on the master channel, while a dropped
// packet produces no output. tlast marks the final byte of a packet and tuser
// marks the last output word caused by one input word.
// The front end accepts one word per cycle while tready is high. An accepted
// stream byte passes the lookup stage, the queue and the output register on
// its way out. The PID byte of a kept packet expands into three output words,
// so the output side runs one word per cycle while the receiver is ready, and
// a small queue between lookup and output absorbs the burst.
// After reset the drop table is cleared one entry per cycle, all PID_COUNT
// entries in turn; tready stays low during that pass.
// When the receiver holds tready low the output word is kept, the queue
// fills and the slave tready drops until space frees up.
`default_nettype none

module ts_pid_drop_filter_top #(
    parameter int PACKET_BYTES = 188,
    parameter int PID_COUNT    = 8192
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // data_byte[7:0], table_pid[20:8], table_drop[21]
    input  wire logic        i_s_tuser,  // req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // out_byte[7:0]
    output logic             o_m_tuser,  // run_last
    output logic             o_m_tlast
);

    logic             push;
    logic             full;
    tspf_pkg::t_entry push_entry;
    logic             q_valid;
    tspf_pkg::t_entry q_entry;
    logic             pop;

    tspf_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .PID_COUNT    (PID_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_req   (tspf_pkg::t_req'(i_s_tuser)),
        .i_byte  (i_s_tdata[7:0]),
        .i_pid   (i_s_tdata[20:8]),
        .i_drop  (i_s_tdata[21]),
        .o_push  (push),
        .o_entry (push_entry),
        .i_full  (full)
    );

    tspf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    tspf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (q_entry),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_byte     (o_m_tdata),
        .o_run_last (o_m_tuser),
        .o_pkt_last (o_m_tlast)
    );

endmodule

`default_nettype wire

### design/tspf_chk.sv
`default_nettype none

module tspf_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [23:0] i_s_tdata,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    a_last_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser)
        else $error("packet end not at end of run");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready during table clear");

endmodule

bind ts_pid_drop_filter_top tspf_chk u_chk (.*);

`default_nettype wire

### test/testbench.sv
module testbench;

    localparam int PACKET_BYTES = 188;
    localparam int PID_COUNT    = 8192;
    localparam int RANDOM_WORDS = 410;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        tspf_pkg::t_req req;
        logic [7:0]     data;
        logic [12:0]    pid;
        logic           drop;
        logic           typed;
        logic [1:0]     n_typed;
        logic [23:0]    typed_bytes;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       packet_last;
    } t_out_word;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [23:0] i_s_tdata  = '0;
    logic        i_s_tuser  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    ts_pid_drop_filter_top #(
        .PACKET_BYTES(PACKET_BYTES),
        .PID_COUNT   (PID_COUNT)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_out_word   expected_words[$];
    int          pkt_pos = 0;
    logic [7:0]  hdr_b0 = '0;
    logic [7:0]  hdr_b1 = '0;
    logic        keep_pkt = 1'b0;
    logic        drop_bits [PID_COUNT];

    int          errors = 0;
    int          words_sent = 0;
    int          table_writes = 0;
    int          kept_pkts = 0;
    int          dropped_pkts = 0;
    int          words_seen = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;

    int          mode = 0;
    int          mode_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic [1:0]  phase = '0;

    function automatic t_out_word mk_word(logic [7:0] b, logic rl, logic pl);
        mk_word = {b, rl, pl};
    endfunction

    function automatic t_stim_row stim_row(tspf_pkg::t_req req, logic [7:0] data,
                                           logic [12:0] pid, logic drop, logic typed,
                                           logic [1:0] n, logic [23:0] bytes);
        stim_row = {req, data, pid, drop, typed, n, bytes};
    endfunction

    function automatic logic [12:0] pick_pid(int hot_in_four);
        if ($urandom_range(0, 3) < hot_in_four) begin
            case ($urandom_range(0, 5))
                0: return 13'd0;
                1: return 13'd1;
                2: return 13'd255;
                3: return 13'(PID_COUNT - 1);
                4: return 13'h1000;
                default: return 13'h1fff;
            endcase
        end
        return 13'($urandom_range(0, 8191));
    endfunction

    task automatic filter_word(input tspf_pkg::t_req req, input logic [7:0] data,
                               input logic [12:0] pid, input logic drop, input bit record);
        logic        last;
        logic [12:0] pkt_pid;
        last = (pkt_pos >= PACKET_BYTES - 1);
        if (req == tspf_pkg::REQ_TABLE) begin
            table_writes++;
            if (pid < PID_COUNT) begin
                drop_bits[pid] = drop;
            end
        end else begin
            if (pkt_pos == 0) begin
                hdr_b0 = data;
            end else if (pkt_pos == 1) begin
                hdr_b1 = data;
            end else if (pkt_pos == 2) begin
                pkt_pid  = {hdr_b1[4:0], data};
                keep_pkt = 1'b0;
                if (pkt_pid < PID_COUNT) begin
                    keep_pkt = !drop_bits[pkt_pid];
                end
                if (keep_pkt) begin
                    kept_pkts++;
                end else begin
                    dropped_pkts++;
                end
                if (keep_pkt && record) begin
                    expected_words.push_back(mk_word(hdr_b0, 1'b0, 1'b0));
                    expected_words.push_back(mk_word(hdr_b1, 1'b0, 1'b0));
                    expected_words.push_back(mk_word(data, 1'b1, last));
                end
            end else if (keep_pkt && record) begin
                expected_words.push_back(mk_word(data, 1'b1, last));
            end
            pkt_pos = last ? 0 : pkt_pos + 1;
        end
    endtask

    task automatic send_word(input tspf_pkg::t_req req, input logic [7:0] data,
                             input logic [12:0] pid, input logic drop, input bit record);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, drop, pid, data};
        i_s_tuser  <= req;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        words_sent++;
        filter_word(req, data, pid, drop, record);
    endtask

    task automatic pace_sender();
        int gap;
        if (no_gaps || burst_left > 0) begin
            if (burst_left > 0) burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    initial begin : stimulus
        t_stim_row   rows[$];
        t_stim_row   r;
        int          i;
        int          k;
        logic [7:0]  data;
        logic [12:0] tgt_pid;

        for (i = 0; i < PID_COUNT; i++) drop_bits[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first packet starts right after reset with an empty table, so it is kept.
        // Its PID byte follows a byte 1 whose upper three bits must be ignored.
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'h47, 13'h1fff, 1'b1, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'he0, 13'h0000, 1'b0, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'hff, 13'h1555, 1'b1, 1'b1, 2'd3,
                                24'h47e0ff));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'hff, 13'd255, 1'b1, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'h00, 13'h1fff, 1'b0, 1'b1, 2'd1,
                                24'h000000));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'h00, 13'h1fff, 1'b1, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'h5a, 13'h1000, 1'b1, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'ha5, 13'(PID_COUNT - 1), 1'b1, 1'b1,
                                2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'h00, 13'd0, 1'b1, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'h00, 13'd0, 1'b0, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'h00, 13'd1, 1'b1, 1'b1, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'hff, 13'h0aaa, 1'b1, 1'b1, 2'd1,
                                24'hff0000));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'h80, 13'h0000, 1'b0, 1'b0, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'h00, 13'd255, 1'b0, 1'b0, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'h01, 13'h1234, 1'b1, 1'b0, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'h7f, 13'h0fff, 1'b0, 1'b0, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_TABLE, 8'h3c, 13'd4096, 1'b1, 1'b0, 2'd0, 24'h0));
        rows.push_back(stim_row(tspf_pkg::REQ_STREAM, 8'h55, 13'h1fff, 1'b1, 1'b0, 2'd0, 24'h0));

        for (i = 0; i < rows.size(); i++) begin
            r = rows[i];
            send_word(r.req, r.data, r.pid, r.drop, !r.typed);
            if (r.typed) begin
                for (k = 0; k < r.n_typed; k++) begin
                    expected_words.push_back(mk_word(r.typed_bytes[23 - 8 * k -: 8],
                                                     k == r.n_typed - 1, 1'b0));
                end
            end
            pace_sender();
        end

        tgt_pid = '0;
        for (i = 0; i < RANDOM_WORDS; i++) begin
            no_gaps = (i >= 100 && i < 200);
            if (i == 250) begin
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while (expected_words.size() != 0);
            end
            if ($urandom_range(0, 7) == 0) begin
                send_word(tspf_pkg::REQ_TABLE, 8'($urandom), pick_pid(3), 1'($urandom), 1'b1);
            end else begin
                case (pkt_pos)
                    0: begin
                        data    = ($urandom_range(0, 3) != 0) ? 8'h47 : 8'($urandom);
                        tgt_pid = pick_pid(2);
                    end
                    1: data = {3'($urandom), tgt_pid[12:8]};
                    2: data = tgt_pid[7:0];
                    default: data = 8'($urandom);
                endcase
                send_word(tspf_pkg::REQ_STREAM, data, 13'($urandom), 1'($urandom), 1'b1);
            end
            pace_sender();
        end

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d table writes); %0d packets kept, %0d dropped.",
                 words_sent, table_writes, kept_pkts, dropped_pkts);
        $display("Checked %0d output words under sender gaps and receiver stalls.",
                 words_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(posedge i_clk) begin : receiver
        t_out_word got;
        t_out_word want;
        logic      ready;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got = {o_m_tdata, o_m_tuser, o_m_tlast};
            words_seen++;
            if (expected_words.size() == 0) begin
                $error("Output word %02h arrived with nothing expected", o_m_tdata);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                    errors++;
                end
                if (got.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                    errors++;
                end
                if (got.packet_last !== want.packet_last) begin
                    $error("packet_last: expected %0b, got %0b",
                           want.packet_last, got.packet_last);
                    errors++;
                end
            end
        end

        // One long hold-off lets the output queue fill so the input side must stall.
        if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
        end else if (words_seen >= HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            ready     = 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            phase++;
            case (mode)
                0: ready = 1'b1;
                1: ready = 1'($urandom_range(0, 1));
                default: ready = (phase != 2'd3);
            endcase
        end
        i_m_tready <= ready;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycle_count, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

### files.f
design/tspf_pkg.sv
design/tspf_front.sv
design/tspf_fifo.sv
design/tspf_back.sv
design/ts_pid_drop_filter_top.sv
design/tspf_chk.sv
test/testbench.sv
